### src/rbst_pkg.sv
`default_nettype none

package rbst_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_LANES = 2 * NUM_AXES;
  localparam int unsigned NUM_IN_FIELDS = 12;
  localparam int unsigned OUT_DATA_W = 8;

endpackage

`default_nettype wire

### src/ray_box_slab_test.sv
// A word passes the input, overflow-check, restoring division, slab-bound and output registers.
// Throughput: one word per cycle when not stalled; every slab quotient has one restoring
// division stage per quotient bit, and the six quotients of an item run side by side in them.
// A stalled output halts the whole pipeline in place, so nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears every valid bit; data registers are not reset.
`default_nettype none

module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              s_axis_tvalid_i,
  output logic                                                   s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z, each COORD_WIDTH bits, then zero padding.
  input  wire logic [((NUM_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                                   m_axis_tvalid_o,
  input  wire logic                                              m_axis_tready_i,
  // hit in bit 0, zero padding above.
  output logic [OUT_DATA_W-1:0]                                  m_axis_tdata_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned NW = W + F;
  localparam int unsigned XW = 2 * W + F;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [W-1:0]  quo;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0]       lane;
    logic  [NUM_AXES-1:0][W-1:0] den;
    logic  [NUM_AXES-1:0]        dz;
    logic                        ok;
  } item_t;

  logic ce;

  logic  a_vld_q;
  item_t a_d, a_q;

  logic  pipe_vld_q [0:W];
  item_t pipe_q     [0:W];
  item_t b_d;

  logic                      e1_vld_q;
  logic signed [W-1:0]       e1_near_d [NUM_AXES];
  logic signed [W-1:0]       e1_far_d  [NUM_AXES];
  logic signed [W-1:0]       e1_near_q [NUM_AXES];
  logic signed [W-1:0]       e1_far_q  [NUM_AXES];
  logic [NUM_AXES-1:0]       e1_dz_q;
  logic                      e1_ok_q;

  logic out_vld_q;
  logic hit_d, hit_q;

  assign ce = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = ce;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-1){1'b0}}, hit_q};

  // Input stage: exact differences, magnitudes and the zero-direction containment test.
  always_comb begin
    logic signed [W-1:0] o, d, lo, hi, mn, mx;
    logic signed [W:0]   df1, df2, ng1, ng2;
    logic [W-1:0]        dneg;
    a_d = '0;
    a_d.ok = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      o  = s_axis_tdata_i[a*W +: W];
      d  = s_axis_tdata_i[(NUM_AXES+a)*W +: W];
      lo = s_axis_tdata_i[(2*NUM_AXES+a)*W +: W];
      hi = s_axis_tdata_i[(3*NUM_AXES+a)*W +: W];
      df1 = {lo[W-1], lo} - {o[W-1], o};
      df2 = {hi[W-1], hi} - {o[W-1], o};
      ng1 = -df1;
      ng2 = -df2;
      dneg = -d;
      mn = (lo < hi) ? lo : hi;
      mx = (lo < hi) ? hi : lo;
      a_d.dz[a]  = (d == '0);
      a_d.den[a] = d[W-1] ? dneg : d;
      if (d == '0 && (o < mn || o > mx)) begin
        a_d.ok = 1'b0;
      end
      a_d.lane[2*a].rem   = {(df1[W] ? ng1[W-1:0] : df1[W-1:0]), {F{1'b0}}};
      a_d.lane[2*a].neg   = df1[W] ^ d[W-1];
      a_d.lane[2*a+1].rem = {(df2[W] ? ng2[W-1:0] : df2[W-1:0]), {F{1'b0}}};
      a_d.lane[2*a+1].neg = df2[W] ^ d[W-1];
    end
  end

  // Quotients of 2^W or more saturate whatever their sign.
  always_comb begin
    b_d = a_q;
    for (int l = 0; l < NUM_LANES; l++) begin
      b_d.lane[l].ovf = XW'(a_q.lane[l].rem) >= (XW'(a_q.den[l/2]) << W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q       <= 1'b0;
      pipe_vld_q[0] <= 1'b0;
    end else if (ce) begin
      a_vld_q       <= s_axis_tvalid_i;
      pipe_vld_q[0] <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      a_q       <= a_d;
      pipe_q[0] <= b_d;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int unsigned J = W - 1 - k;
    item_t nxt;

    always_comb begin
      logic [XW-1:0] den_x, rem_x;
      nxt = pipe_q[k];
      for (int l = 0; l < NUM_LANES; l++) begin
        den_x = XW'(pipe_q[k].den[l/2]) << J;
        rem_x = XW'(pipe_q[k].lane[l].rem);
        if (rem_x >= den_x) begin
          nxt.lane[l].rem    = NW'(rem_x - den_x);
          nxt.lane[l].quo[J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_vld_q[k+1] <= 1'b0;
      end else if (ce) begin
        pipe_vld_q[k+1] <= pipe_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        pipe_q[k+1] <= nxt;
      end
    end
  end

  // Saturate and sign each quotient, then order the two bounds of each axis.
  always_comb begin
    logic signed [W-1:0] t [NUM_LANES];
    logic [W-1:0]        q, qn;
    for (int l = 0; l < NUM_LANES; l++) begin
      q  = pipe_q[W].lane[l].quo;
      qn = -q;
      if (!pipe_q[W].lane[l].neg) begin
        t[l] = (pipe_q[W].lane[l].ovf || q[W-1]) ? {1'b0, {(W-1){1'b1}}} : q;
      end else if (pipe_q[W].lane[l].ovf || q > {1'b1, {(W-1){1'b0}}}) begin
        t[l] = {1'b1, {(W-1){1'b0}}};
      end else begin
        t[l] = qn;
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      e1_near_d[a] = (t[2*a] < t[2*a+1]) ? t[2*a] : t[2*a+1];
      e1_far_d[a]  = (t[2*a] < t[2*a+1]) ? t[2*a+1] : t[2*a];
    end
  end

  always_comb begin
    logic signed [W-1:0] tmin, tmax;
    tmin = {1'b1, {(W-1){1'b0}}};
    tmax = {1'b0, {(W-1){1'b1}}};
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!e1_dz_q[a]) begin
        if (e1_near_q[a] > tmin) begin
          tmin = e1_near_q[a];
        end
        if (e1_far_q[a] < tmax) begin
          tmax = e1_far_q[a];
        end
      end
    end
    hit_d = e1_ok_q && (tmax >= tmin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (ce) begin
      e1_vld_q  <= pipe_vld_q[W];
      out_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      e1_near_q <= e1_near_d;
      e1_far_q  <= e1_far_d;
      e1_dz_q   <= pipe_q[W].dz;
      e1_ok_q   <= pipe_q[W].ok;
      hit_q     <= hit_d;
    end
  end

`ifndef ASSERT_OFF
  a_e1_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    e1_vld_q && ce |=> m_axis_tvalid_o)
    else $error("valid word lost between the last two stages");

  a_all_zero_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    e1_vld_q && ce && (&e1_dz_q) |=> m_axis_tdata_o[0] == $past(e1_ok_q))
    else $error("hit differs from containment when no axis has a direction");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable(pipe_vld_q[0]) && $stable(a_vld_q) && $stable(e1_vld_q))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire
